>>> rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the checker files.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge while the reset is released.
`define ASSERT_RST(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every rising edge, also during reset.
`define ASSERT_ANY(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> rtl/core/bc3_pkg.sv
// ----------------------------------------------------------------------------
// bc3_pkg
// Types, constant tables and fixed-divisor helpers for the BC3 block decoder.
// ----------------------------------------------------------------------------
package bc3_pkg;

  localparam int unsigned Max5 = 31;
  localparam int unsigned Max6 = 63;
  localparam int unsigned Full = 255;

  localparam int unsigned NumPix = 16;
  localparam int unsigned PixW   = 4;
  localparam int unsigned CIdxW  = 2;
  localparam int unsigned AIdxW  = 3;
  localparam int unsigned NumInt = 6;

  // Reciprocal constants, exact over the numerator ranges used here.
  localparam int unsigned Recip3 = 683;
  localparam int unsigned Shift3 = 11;
  localparam int unsigned Recip5 = 1639;
  localparam int unsigned Shift5 = 13;
  localparam int unsigned Recip7 = 2341;
  localparam int unsigned Shift7 = 14;

  typedef logic [31:0][7:0] w5_tab_t;
  typedef logic [63:0][7:0] w6_tab_t;

  typedef struct packed {
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
  } rgb_t;

  typedef struct packed {
    logic [9:0] r;
    logic [9:0] g;
    logic [9:0] b;
  } rgb_sum_t;

  function automatic w5_tab_t build_w5();
    w5_tab_t t;
    for (int i = 0; i < 32; i++) begin
      t[i] = 8'((i * Full) / Max5);
    end
    return t;
  endfunction

  function automatic w6_tab_t build_w6();
    w6_tab_t t;
    for (int i = 0; i < 64; i++) begin
      t[i] = 8'((i * Full) / Max6);
    end
    return t;
  endfunction

  localparam w5_tab_t W5_TAB = build_w5();
  localparam w6_tab_t W6_TAB = build_w6();

  function automatic logic [7:0] div3(input logic [9:0] x);
    logic [19:0] p;
    p = 20'(x) * 20'(Recip3);
    return 8'(p >> Shift3);
  endfunction

  function automatic logic [7:0] div5(input logic [10:0] x);
    logic [21:0] p;
    p = 22'(x) * 22'(Recip5);
    return 8'(p >> Shift5);
  endfunction

  function automatic logic [7:0] div7(input logic [10:0] x);
    logic [22:0] p;
    p = 23'(x) * 23'(Recip7);
    return 8'(p >> Shift7);
  endfunction

endpackage

>>> rtl/core/bc3_block_decoder_top.sv
// ----------------------------------------------------------------------------
// bc3_block_decoder_top
// BC3 texture block decoder: one 16-byte block in, sixteen RGBA pixels out.
// ----------------------------------------------------------------------------
// Channel   Direction  Transfer rule          Payload
// input     in         start & !busy          in_alpha_word, in_color_word
// result    out        out_valid, one cycle   out_red/green/blue/alpha,
//                                             out_column, out_row, out_last_pixel
//
// A block passes three register stages (capture, endpoint widening, weighted
// sums), then loads a palette register and emits one pixel per cycle.
// The first pixel reaches the ports through the palette register and the output
// register; sustained throughput is set by the single pixel output port.
// A new block is taken while the previous one is still being emitted.
// Reset is synchronous and clears the valid bits only.
// The receiver cannot stall; busy rises only when all stages hold blocks.
// ----------------------------------------------------------------------------
module bc3_block_decoder_top
  import bc3_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [63:0] in_alpha_word,
  input  logic [63:0] in_color_word,
  output logic        out_valid,
  output logic [7:0]  out_red,
  output logic [7:0]  out_green,
  output logic [7:0]  out_blue,
  output logic [7:0]  out_alpha,
  output logic [1:0]  out_column,
  output logic [1:0]  out_row,
  output logic        out_last_pixel
);

  logic        s1_valid_r, s2_valid_r, s3_valid_r, hold_valid_r;
  logic        s1_adv, s2_adv, s3_adv;
  logic        s1_free, s2_free, s3_free, hold_free, hold_done;
  logic        accept;

  logic [63:0] s1_aw_r, s1_cw_r;

  rgb_t        s2_c0_r, s2_c1_r;
  logic [7:0]  s2_a0_r, s2_a1_r;
  logic [31:0] s2_cidx_r;
  logic [47:0] s2_aidx_r;

  rgb_t        s3_c0_r, s3_c1_r;
  rgb_sum_t    s3_cs0_r, s3_cs1_r;
  logic [7:0]  s3_a0_r, s3_a1_r;
  logic        s3_mode7_r;
  logic [NumInt-1:0][10:0] s3_anum_r;
  logic [NumInt-1:0][10:0] anum_nxt;
  logic        mode7_nxt;
  logic [31:0] s3_cidx_r;
  logic [47:0] s3_aidx_r;

  rgb_t        hold_col_r [4];
  logic [7:0]  hold_alp_r [8];
  logic [31:0] hold_cidx_r;
  logic [47:0] hold_aidx_r;
  logic [PixW-1:0] cnt_r;

  logic        out_valid_r;
  rgb_t        out_col_r;
  logic [7:0]  out_alpha_r;
  logic [PixW-1:0] out_pos_r;
  logic        out_last_r;

  assign hold_done = hold_valid_r && (cnt_r == PixW'(NumPix - 1));
  assign hold_free = !hold_valid_r || hold_done;
  assign s3_adv    = s3_valid_r && hold_free;
  assign s3_free   = !s3_valid_r || s3_adv;
  assign s2_adv    = s2_valid_r && s3_free;
  assign s2_free   = !s2_valid_r || s2_adv;
  assign s1_adv    = s1_valid_r && s2_free;
  assign s1_free   = !s1_valid_r || s1_adv;
  assign busy      = !s1_free;
  assign accept    = start && !busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r   <= 1'b0;
      s2_valid_r   <= 1'b0;
      s3_valid_r   <= 1'b0;
      hold_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      if (accept) begin
        s1_valid_r <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_r <= 1'b0;
      end
      if (s1_adv) begin
        s2_valid_r <= 1'b1;
      end else if (s2_adv) begin
        s2_valid_r <= 1'b0;
      end
      if (s2_adv) begin
        s3_valid_r <= 1'b1;
      end else if (s3_adv) begin
        s3_valid_r <= 1'b0;
      end
      if (s3_adv) begin
        hold_valid_r <= 1'b1;
      end else if (hold_done) begin
        hold_valid_r <= 1'b0;
      end
      out_valid_r <= hold_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_aw_r <= in_alpha_word;
      s1_cw_r <= in_color_word;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      s2_c0_r.r <= W5_TAB[s1_cw_r[15:11]];
      s2_c0_r.g <= W6_TAB[s1_cw_r[10:5]];
      s2_c0_r.b <= W5_TAB[s1_cw_r[4:0]];
      s2_c1_r.r <= W5_TAB[s1_cw_r[31:27]];
      s2_c1_r.g <= W6_TAB[s1_cw_r[26:21]];
      s2_c1_r.b <= W5_TAB[s1_cw_r[20:16]];
      s2_a0_r   <= s1_aw_r[7:0];
      s2_a1_r   <= s1_aw_r[15:8];
      s2_cidx_r <= s1_cw_r[63:32];
      s2_aidx_r <= s1_aw_r[63:16];
    end
  end

  always_comb begin
    mode7_nxt = s2_a0_r > s2_a1_r;
    for (int k = 0; k < NumInt; k++) begin
      if (mode7_nxt) begin
        anum_nxt[k] = 11'((6 - k) * s2_a0_r + (k + 1) * s2_a1_r);
      end else if (k < 4) begin
        anum_nxt[k] = 11'((4 - k) * s2_a0_r + (k + 1) * s2_a1_r);
      end else begin
        anum_nxt[k] = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s2_adv) begin
      s3_c0_r    <= s2_c0_r;
      s3_c1_r    <= s2_c1_r;
      s3_cs0_r.r <= {1'b0, s2_c0_r.r, 1'b0} + 10'(s2_c1_r.r);
      s3_cs0_r.g <= {1'b0, s2_c0_r.g, 1'b0} + 10'(s2_c1_r.g);
      s3_cs0_r.b <= {1'b0, s2_c0_r.b, 1'b0} + 10'(s2_c1_r.b);
      s3_cs1_r.r <= {1'b0, s2_c1_r.r, 1'b0} + 10'(s2_c0_r.r);
      s3_cs1_r.g <= {1'b0, s2_c1_r.g, 1'b0} + 10'(s2_c0_r.g);
      s3_cs1_r.b <= {1'b0, s2_c1_r.b, 1'b0} + 10'(s2_c0_r.b);
      s3_a0_r    <= s2_a0_r;
      s3_a1_r    <= s2_a1_r;
      s3_mode7_r <= mode7_nxt;
      s3_anum_r  <= anum_nxt;
      s3_cidx_r  <= s2_cidx_r;
      s3_aidx_r  <= s2_aidx_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s3_adv) begin
      hold_col_r[0]   <= s3_c0_r;
      hold_col_r[1]   <= s3_c1_r;
      hold_col_r[2].r <= div3(s3_cs0_r.r);
      hold_col_r[2].g <= div3(s3_cs0_r.g);
      hold_col_r[2].b <= div3(s3_cs0_r.b);
      hold_col_r[3].r <= div3(s3_cs1_r.r);
      hold_col_r[3].g <= div3(s3_cs1_r.g);
      hold_col_r[3].b <= div3(s3_cs1_r.b);
      hold_alp_r[0]   <= s3_a0_r;
      hold_alp_r[1]   <= s3_a1_r;
      for (int k = 0; k < NumInt; k++) begin
        if (s3_mode7_r) begin
          hold_alp_r[k + 2] <= div7(s3_anum_r[k]);
        end else if (k < 4) begin
          hold_alp_r[k + 2] <= div5(s3_anum_r[k]);
        end else if (k == 4) begin
          hold_alp_r[k + 2] <= 8'd0;
        end else begin
          hold_alp_r[k + 2] <= 8'(Full);
        end
      end
      hold_cidx_r <= s3_cidx_r;
      hold_aidx_r <= s3_aidx_r;
      cnt_r       <= '0;
    end else if (hold_valid_r) begin
      hold_cidx_r <= hold_cidx_r >> CIdxW;
      hold_aidx_r <= hold_aidx_r >> AIdxW;
      cnt_r       <= cnt_r + PixW'(1);
    end
  end

  always_ff @(posedge clk) begin
    out_col_r   <= hold_col_r[hold_cidx_r[CIdxW-1:0]];
    out_alpha_r <= hold_alp_r[hold_aidx_r[AIdxW-1:0]];
    out_pos_r   <= cnt_r;
    out_last_r  <= cnt_r == PixW'(NumPix - 1);
  end

  assign out_valid      = out_valid_r;
  assign out_red        = out_col_r.r;
  assign out_green      = out_col_r.g;
  assign out_blue       = out_col_r.b;
  assign out_alpha      = out_alpha_r;
  assign out_column     = out_pos_r[1:0];
  assign out_row        = out_pos_r[3:2];
  assign out_last_pixel = out_last_r;

endmodule

>>> rtl/core/bc3_chk.sv
// ----------------------------------------------------------------------------
// bc3_chk
// Port-level checks on the pixel sequence of the BC3 block decoder.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module bc3_chk (
  input logic       clk,
  input logic       rst_n,
  input logic       start,
  input logic       busy,
  input logic       out_valid,
  input logic [1:0] out_column,
  input logic [1:0] out_row,
  input logic       out_last_pixel
);

  logic unused_in;

  assign unused_in = start & busy;

  `ASSERT_ANY(a_reset_quiet, clk, !rst_n |=> !out_valid, "Pixel transfer right after reset.")
  `ASSERT_RST(a_last_pos, clk, rst_n, out_valid && out_last_pixel |-> out_column == 2'd3 && out_row == 2'd3, "Last pixel is not at the bottom right corner.")
  `ASSERT_RST(a_tile_burst, clk, rst_n, out_valid && !out_last_pixel |=> out_valid, "Gap inside the pixel burst of a tile.")
  `ASSERT_RST(a_col_step, clk, rst_n, out_valid && !out_last_pixel |=> out_column == 2'($past(out_column) + 2'd1), "Pixel column did not advance by one.")

endmodule

bind bc3_block_decoder_top bc3_chk u_bc3_chk (
  .clk            (clk),
  .rst_n          (rst_n),
  .start          (start),
  .busy           (busy),
  .out_valid      (out_valid),
  .out_column     (out_column),
  .out_row        (out_row),
  .out_last_pixel (out_last_pixel)
);
